// ===== src/fac_pkg.sv =====
// fall alert controller package: shared types, register map and constants
// used by the csr, square, core and top modules; depends on nothing
`default_nettype none

package fac_pkg;

   localparam int unsigned AGE_W = 16;
   localparam int unsigned SQ_W = 32;
   localparam int unsigned CSR_AW = 5;
   localparam int unsigned CSR_DW = 32;

   localparam logic [AGE_W-1:0] AGE_MAX = 16'hFFFF;

   // register map, byte address 4*index
   typedef enum logic [2:0] {
      REG_THRESHOLD_SQ = 3'd0,
      REG_CANCEL_WINDOW = 3'd1,
      REG_IMPACT_HOLD = 3'd2,
      REG_BEEP = 3'd3,
      REG_TOGGLE = 3'd4,
      REG_REPORT_PERIOD = 3'd5
   } csr_index_type;

   localparam logic [SQ_W-1:0] RST_THRESHOLD_SQ = 32'd104857600;
   localparam logic [AGE_W-1:0] RST_CANCEL_WINDOW = 16'd3000;
   localparam logic [AGE_W-1:0] RST_IMPACT_HOLD = 16'd10000;
   localparam logic [AGE_W-1:0] RST_BEEP = 16'd200;
   localparam logic [AGE_W-1:0] RST_TOGGLE = 16'd500;
   localparam logic [AGE_W-1:0] RST_REPORT_PERIOD = 16'd60000;

   typedef struct packed {
      logic [SQ_W-1:0] threshold_sq;
      logic [AGE_W-1:0] cancel_window;
      logic [AGE_W-1:0] impact_hold;
      logic [AGE_W-1:0] beep;
      logic [AGE_W-1:0] toggle;
      logic [AGE_W-1:0] report_period;
   } cfg_type;

   // registered input stage: squared axes and button flags
   typedef struct packed {
      logic accel_valid;
      logic [SQ_W-1:0] sq_x;
      logic [SQ_W-1:0] sq_y;
      logic [SQ_W-1:0] sq_z;
      logic sos_press;
      logic cancel_press;
   } sq_item_type;

   typedef struct packed {
      logic buzzer_on;
      logic impact_flag;
      logic report_valid;
      logic report_periodic;
      logic report_impact;
      logic report_sos;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== src/fac_if.sv =====
// fall alert controller channels: tick input and result interfaces
// depends on nothing
`default_nettype none

interface fac_req_if;
   logic valid;
   logic ready;
   logic accel_valid;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic sos_press;
   logic cancel_press;

   modport source (
      output valid, accel_valid, accel_x, accel_y, accel_z, sos_press, cancel_press,
      input ready
   );
   modport sink (
      input valid, accel_valid, accel_x, accel_y, accel_z, sos_press, cancel_press,
      output ready
   );
endinterface

interface fac_rsp_if;
   logic valid;
   logic ready;
   logic buzzer_on;
   logic impact_flag;
   logic report_valid;
   logic report_periodic;
   logic report_impact;
   logic report_sos;

   modport source (
      output valid, buzzer_on, impact_flag, report_valid, report_periodic,
      report_impact, report_sos,
      input ready
   );
   modport sink (
      input valid, buzzer_on, impact_flag, report_valid, report_periodic,
      report_impact, report_sos,
      output ready
   );
endinterface

`default_nettype wire

// ===== src/fac_csr.sv =====
// fall alert controller configuration registers behind an apb-style port
// depends on fac_pkg
`default_nettype none

module fac_csr (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_psel,
   input  wire logic csr_penable,
   input  wire logic csr_pwrite,
   input  wire logic [fac_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [fac_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [fac_pkg::CSR_DW-1:0] csr_prdata,
   output logic csr_pready,
   output fac_pkg::cfg_type cfg
);
   import fac_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   csr_index_type idx;
   logic wr_en;

   assign idx = csr_index_type'(csr_paddr[CSR_AW-1:2]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_THRESHOLD_SQ: cfg_in.threshold_sq = csr_pwdata;
            REG_CANCEL_WINDOW: cfg_in.cancel_window = csr_pwdata[AGE_W-1:0];
            REG_IMPACT_HOLD: cfg_in.impact_hold = csr_pwdata[AGE_W-1:0];
            REG_BEEP: cfg_in.beep = csr_pwdata[AGE_W-1:0];
            REG_TOGGLE: cfg_in.toggle = csr_pwdata[AGE_W-1:0];
            REG_REPORT_PERIOD: cfg_in.report_period = csr_pwdata[AGE_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_THRESHOLD_SQ: csr_prdata = cfg_ff.threshold_sq;
         REG_CANCEL_WINDOW: csr_prdata = {16'd0, cfg_ff.cancel_window};
         REG_IMPACT_HOLD: csr_prdata = {16'd0, cfg_ff.impact_hold};
         REG_BEEP: csr_prdata = {16'd0, cfg_ff.beep};
         REG_TOGGLE: csr_prdata = {16'd0, cfg_ff.toggle};
         REG_REPORT_PERIOD: csr_prdata = {16'd0, cfg_ff.report_period};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_sq <= RST_THRESHOLD_SQ;
         cfg_ff.cancel_window <= RST_CANCEL_WINDOW;
         cfg_ff.impact_hold <= RST_IMPACT_HOLD;
         cfg_ff.beep <= RST_BEEP;
         cfg_ff.toggle <= RST_TOGGLE;
         cfg_ff.report_period <= RST_REPORT_PERIOD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/fac_square.sv =====
// fall alert controller input stage: takes a tick item and registers the
// squared axis magnitudes with the button flags; depends on fac_pkg, fac_if
`default_nettype none

module fac_square (
   input  wire logic clock,
   input  wire logic reset,
   fac_req_if.sink req,
   input  wire logic take,
   output logic s1_valid,
   output fac_pkg::sq_item_type s1_item
);
   import fac_pkg::*;

   logic s1_valid_ff;
   logic s1_valid_in;
   sq_item_type s1_item_ff;
   sq_item_type s1_item_in;
   logic accept;

   function automatic logic [SQ_W-1:0] square16(input logic [15:0] v);
      logic [15:0] mag;
      // |-32768| still fits 16 bits unsigned
      mag = v[15] ? (16'd0 - v) : v;
      return mag * mag;
   endfunction

   assign req.ready = !s1_valid_ff || take;
   assign accept = req.valid && req.ready;
   assign s1_valid = s1_valid_ff;
   assign s1_item = s1_item_ff;

   always_comb begin
      s1_item_in.accel_valid = req.accel_valid;
      s1_item_in.sq_x = square16(req.accel_x);
      s1_item_in.sq_y = square16(req.accel_y);
      s1_item_in.sq_z = square16(req.accel_z);
      s1_item_in.sos_press = req.sos_press;
      s1_item_in.cancel_press = req.cancel_press;

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (take) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= s1_item_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/fac_core.sv =====
// fall alert controller tick logic: impact compare, alert timers, reports,
// buzzer, and the result register; depends on fac_pkg, fac_if
`default_nettype none

module fac_core (
   input  wire logic clock,
   input  wire logic reset,
   input  wire fac_pkg::cfg_type cfg,
   input  wire logic s1_valid,
   input  wire fac_pkg::sq_item_type s1_item,
   output logic take,
   fac_rsp_if.source rsp
);
   import fac_pkg::*;

   logic impact_active_ff, impact_active_in;
   logic [AGE_W-1:0] impact_age_ff, impact_age_in;
   logic fall_alert_ff, fall_alert_in;
   logic [AGE_W-1:0] fall_age_ff, fall_age_in;
   logic impact_pending_ff, impact_pending_in;
   logic sos_pending_ff, sos_pending_in;
   logic alarm_on_ff, alarm_on_in;
   logic beep_active_ff, beep_active_in;
   logic [AGE_W-1:0] beep_age_ff, beep_age_in;
   logic toggle_phase_ff, toggle_phase_in;
   logic [AGE_W-1:0] toggle_age_ff, toggle_age_in;
   logic [AGE_W-1:0] report_age_ff, report_age_in;
   logic buzzer_level_ff, buzzer_level_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_item_type res_ff, res_in;
   logic [SQ_W-1:0] sq_sum;
   logic hit;
   logic step;
   logic rep_per, rep_imp, rep_sos;

   function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
      return (a == AGE_MAX) ? a : a + 1'b1;
   endfunction

   // three squares of at most 2^30 each stay below 2^32
   assign sq_sum = s1_item.sq_x + s1_item.sq_y + s1_item.sq_z;
   assign hit = s1_item.accel_valid && (sq_sum > cfg.threshold_sq);

   assign take = !rsp_valid_ff || rsp.ready;
   assign step = s1_valid && take;

   always_comb begin
      impact_active_in = impact_active_ff;
      impact_age_in = impact_age_ff;
      fall_alert_in = fall_alert_ff;
      fall_age_in = fall_age_ff;
      impact_pending_in = impact_pending_ff;
      sos_pending_in = sos_pending_ff;
      alarm_on_in = alarm_on_ff;
      beep_active_in = beep_active_ff;
      beep_age_in = beep_age_ff;
      toggle_phase_in = toggle_phase_ff;
      toggle_age_in = toggle_age_ff;
      report_age_in = report_age_ff;
      buzzer_level_in = buzzer_level_ff;
      res_in = res_ff;
      rep_per = 1'b0;
      rep_imp = 1'b0;
      rep_sos = 1'b0;

      if (step) begin
         impact_age_in = age_inc(impact_age_ff);
         fall_age_in = age_inc(fall_age_ff);
         beep_age_in = age_inc(beep_age_ff);
         toggle_age_in = age_inc(toggle_age_ff);
         report_age_in = age_inc(report_age_ff);

         if (s1_item.sos_press) begin
            beep_active_in = 1'b1;
            beep_age_in = '0;
            buzzer_level_in = 1'b1;
            sos_pending_in = 1'b1;
         end

         // cancel is taken before detection in the same tick
         if (s1_item.cancel_press && fall_alert_in && (fall_age_in < cfg.cancel_window)) begin
            fall_alert_in = 1'b0;
            alarm_on_in = 1'b0;
            buzzer_level_in = 1'b0;
            impact_pending_in = 1'b0;
         end

         if (hit && !impact_active_in) begin
            impact_active_in = 1'b1;
            impact_age_in = '0;
            fall_alert_in = 1'b1;
            fall_age_in = '0;
            alarm_on_in = 1'b1;
         end

         if (fall_alert_in && (fall_age_in >= cfg.cancel_window) && !impact_pending_in) begin
            impact_pending_in = 1'b1;
            fall_alert_in = 1'b0;
         end

         // a saturated age always counts as past the hold
         if (impact_active_in &&
             ((impact_age_in > cfg.impact_hold) || (impact_age_in == AGE_MAX))) begin
            impact_active_in = 1'b0;
            fall_alert_in = 1'b0;
            alarm_on_in = 1'b0;
            buzzer_level_in = 1'b0;
         end

         rep_per = report_age_in >= cfg.report_period;
         if (rep_per) begin
            report_age_in = '0;
         end
         rep_imp = impact_pending_in;
         rep_sos = sos_pending_in;
         impact_pending_in = 1'b0;
         sos_pending_in = 1'b0;

         if (beep_active_in) begin
            if (beep_age_in >= cfg.beep) begin
               buzzer_level_in = 1'b0;
               beep_active_in = 1'b0;
            end
         end else if (alarm_on_in) begin
            if (toggle_age_in >= cfg.toggle) begin
               toggle_phase_in = !toggle_phase_in;
               buzzer_level_in = toggle_phase_in;
               toggle_age_in = '0;
            end
         end else begin
            buzzer_level_in = 1'b0;
            toggle_phase_in = 1'b0;
         end

         res_in.buzzer_on = buzzer_level_in;
         res_in.impact_flag = impact_active_in;
         res_in.report_valid = rep_per || rep_imp || rep_sos;
         res_in.report_periodic = rep_per;
         res_in.report_impact = rep_imp;
         res_in.report_sos = rep_sos;
      end

      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         impact_active_ff <= 1'b0;
         impact_age_ff <= '0;
         fall_alert_ff <= 1'b0;
         fall_age_ff <= '0;
         impact_pending_ff <= 1'b0;
         sos_pending_ff <= 1'b0;
         alarm_on_ff <= 1'b0;
         beep_active_ff <= 1'b0;
         beep_age_ff <= '0;
         toggle_phase_ff <= 1'b0;
         toggle_age_ff <= '0;
         report_age_ff <= '0;
         buzzer_level_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         impact_active_ff <= impact_active_in;
         impact_age_ff <= impact_age_in;
         fall_alert_ff <= fall_alert_in;
         fall_age_ff <= fall_age_in;
         impact_pending_ff <= impact_pending_in;
         sos_pending_ff <= sos_pending_in;
         alarm_on_ff <= alarm_on_in;
         beep_active_ff <= beep_active_in;
         beep_age_ff <= beep_age_in;
         toggle_phase_ff <= toggle_phase_in;
         toggle_age_ff <= toggle_age_in;
         report_age_ff <= report_age_in;
         buzzer_level_ff <= buzzer_level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.buzzer_on = res_ff.buzzer_on;
   assign rsp.impact_flag = res_ff.impact_flag;
   assign rsp.report_valid = res_ff.report_valid;
   assign rsp.report_periodic = res_ff.report_periodic;
   assign rsp.report_impact = res_ff.report_impact;
   assign rsp.report_sos = res_ff.report_sos;

endmodule

`default_nettype wire

// ===== src/fall_alert_controller.sv =====
// fall alert controller: one tick item in, one result item out.
// path from item accept to result accept: squaring register, then result register.
// throughput one item per cycle; the result register stalls only on rsp ready low.
// reset (synchronous, active high) clears all timers and flags, empties both stages
// and loads the configuration registers with their defaults. no clearing pass.
// depends on fac_pkg, fac_if, fac_csr, fac_square, fac_core
`default_nettype none

module fall_alert_controller (
   input  wire logic clock,
   input  wire logic reset,
   fac_req_if.sink req_ch,
   fac_rsp_if.source rsp_ch,
   input  wire logic csr_psel,
   input  wire logic csr_penable,
   input  wire logic csr_pwrite,
   input  wire logic [fac_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [fac_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [fac_pkg::CSR_DW-1:0] csr_prdata,
   output logic csr_pready
);
   import fac_pkg::*;

   cfg_type cfg;
   sq_item_type s1_item;
   logic s1_valid;
   logic take;

   fac_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .cfg(cfg)
   );

   fac_square u_square (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .take(take),
      .s1_valid(s1_valid),
      .s1_item(s1_item)
   );

   fac_core u_core (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .s1_valid(s1_valid),
      .s1_item(s1_item),
      .take(take),
      .rsp(rsp_ch)
   );

endmodule

`default_nettype wire

// ===== src/fac_checker.sv =====
// fall alert controller port checker and its bind to the top level
// depends on the top level port names only
`default_nettype none

module fac_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic report_valid,
   input wire logic report_periodic,
   input wire logic report_impact,
   input wire logic report_sos
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // cause bits only with a report
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !report_valid |-> !(report_periodic || report_impact || report_sos))
      else $error("report cause without report");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && report_valid |-> (report_periodic || report_impact || report_sos))
      else $error("report without cause");

   // a fresh result follows an item taken at the request port
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without item");

endmodule

bind fall_alert_controller fac_checker u_fac_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_ch.valid),
   .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .report_valid(rsp_ch.report_valid),
   .report_periodic(rsp_ch.report_periodic),
   .report_impact(rsp_ch.report_impact),
   .report_sos(rsp_ch.report_sos)
);

`default_nettype wire

// ===== tb/tb.sv =====
// testbench for fall_alert_controller: directed tick table, then randomized phases
// and a short wide-timer run, checked item by item against a predictor or typed rows
// depends on fac_pkg, fac_if and the fall_alert_controller rtl
module tb;
   import fac_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_PHASES = 9;
   localparam int PHASE_TICKS = 120;
   localparam int CALM_TICKS = 20;
   localparam logic [31:0] THRESHOLD_MAX = 32'd3221225472;

   typedef struct packed {
      logic accel_valid;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic sos_press;
      logic cancel_press;
   } tick_item_type;

   typedef struct {
      bit is_cfg;
      csr_index_type reg_idx;
      logic [31:0] reg_val;
      tick_item_type tick;
      bit typed;
      rsp_item_type typed_rsp;
   } plan_row_type;

   typedef struct {
      bit typed;
      rsp_item_type rsp;
   } typed_hint_type;

   typedef struct {
      bit impact_active;
      bit [15:0] impact_age;
      bit fall_alert;
      bit [15:0] fall_age;
      bit impact_pending;
      bit sos_pending;
      bit alarm_on;
      bit beep_active;
      bit [15:0] beep_age;
      bit toggle_phase;
      bit [15:0] toggle_age;
      bit [15:0] report_age;
      bit buzzer_level;
   } alert_state_type;

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_COMB, STALL_LONG} stall_mode_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   fac_req_if req_ch();
   fac_rsp_if rsp_ch();

   fall_alert_controller DUT (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   alert_state_type st = '{default: 0};
   cfg_type cfg_shadow;
   rsp_item_type alert_q[$];
   typed_hint_type hint_q[$];
   plan_row_type plan[$];

   int errors = 0;
   int ticks_sent = 0;
   int results_seen = 0;
   int settings = 0;
   int burst_left = 0;
   int idle_cycles = 0;
   int n_impact = 0;
   int n_sos = 0;
   int n_periodic = 0;

   function automatic bit [15:0] bump(input bit [15:0] a);
      return (a == 16'hFFFF) ? a : a + 16'd1;
   endfunction

   function automatic longint unsigned axis_sq(input logic signed [15:0] v);
      longint s;
      s = v;
      if (s < 0) s = -s;
      return s * s;
   endfunction

   // advances the alert state by one tick and returns the result it causes
   function automatic rsp_item_type next_alert(input tick_item_type t);
      rsp_item_type r;
      longint unsigned mag_sq;
      bit per, imp, sos_r;
      st.impact_age = bump(st.impact_age);
      st.fall_age = bump(st.fall_age);
      st.beep_age = bump(st.beep_age);
      st.toggle_age = bump(st.toggle_age);
      st.report_age = bump(st.report_age);

      if (t.sos_press) begin
         st.beep_active = 1;
         st.beep_age = 0;
         st.buzzer_level = 1;
         st.sos_pending = 1;
      end

      if (t.cancel_press && st.fall_alert && st.fall_age < cfg_shadow.cancel_window) begin
         st.fall_alert = 0;
         st.alarm_on = 0;
         st.buzzer_level = 0;
         st.impact_pending = 0;
      end

      if (t.accel_valid) begin
         mag_sq = axis_sq(t.accel_x) + axis_sq(t.accel_y) + axis_sq(t.accel_z);
         if (!st.impact_active && mag_sq > longint'(cfg_shadow.threshold_sq)) begin
            st.impact_active = 1;
            st.impact_age = 0;
            st.fall_alert = 1;
            st.fall_age = 0;
            st.alarm_on = 1;
         end
      end

      if (st.fall_alert && st.fall_age >= cfg_shadow.cancel_window && !st.impact_pending) begin
         st.impact_pending = 1;
         st.fall_alert = 0;
      end

      // a saturated age always counts as past the hold
      if (st.impact_active &&
          (st.impact_age > cfg_shadow.impact_hold || st.impact_age == AGE_MAX)) begin
         st.impact_active = 0;
         st.fall_alert = 0;
         st.alarm_on = 0;
         st.buzzer_level = 0;
      end

      per = st.report_age >= cfg_shadow.report_period;
      if (per) st.report_age = 0;
      imp = st.impact_pending;
      sos_r = st.sos_pending;
      st.impact_pending = 0;
      st.sos_pending = 0;

      if (st.beep_active) begin
         if (st.beep_age >= cfg_shadow.beep) begin
            st.buzzer_level = 0;
            st.beep_active = 0;
         end
      end else if (st.alarm_on) begin
         if (st.toggle_age >= cfg_shadow.toggle) begin
            st.toggle_phase = !st.toggle_phase;
            st.buzzer_level = st.toggle_phase;
            st.toggle_age = 0;
         end
      end else begin
         st.buzzer_level = 0;
         st.toggle_phase = 0;
      end

      r.buzzer_on = st.buzzer_level;
      r.impact_flag = st.impact_active;
      r.report_valid = per | imp | sos_r;
      r.report_periodic = per;
      r.report_impact = imp;
      r.report_sos = sos_r;
      return r;
   endfunction

   function automatic tick_item_type tk(input bit av, input int x, input int y, input int z,
                                        input bit s, input bit c);
      tick_item_type t;
      t.accel_valid = av;
      t.accel_x = x[15:0];
      t.accel_y = y[15:0];
      t.accel_z = z[15:0];
      t.sos_press = s;
      t.cancel_press = c;
      return t;
   endfunction

   function automatic plan_row_type tick_row(input tick_item_type t);
      plan_row_type p;
      p.is_cfg = 0;
      p.reg_idx = REG_THRESHOLD_SQ;
      p.reg_val = '0;
      p.tick = t;
      p.typed = 0;
      p.typed_rsp = '0;
      return p;
   endfunction

   function automatic plan_row_type known_row(input tick_item_type t, input rsp_item_type r);
      plan_row_type p;
      p = tick_row(t);
      p.typed = 1;
      p.typed_rsp = r;
      return p;
   endfunction

   function automatic plan_row_type cfg_row(input csr_index_type idx, input logic [31:0] val);
      plan_row_type p;
      p = tick_row('0);
      p.is_cfg = 1;
      p.reg_idx = idx;
      p.reg_val = val;
      return p;
   endfunction

   function automatic logic signed [15:0] rand_axis(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (!calm && r < 6) return 16'($urandom);
      if (!calm && r < 9) begin
         case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return 16'shFFFF;
         endcase
      end
      return 16'(int'($urandom_range(0, 8000)) - 4000);
   endfunction

   // mostly quiet wear with spikes, sos and cancel presses; calm keeps an alert alive
   function automatic tick_item_type rand_tick(input bit calm);
      tick_item_type t;
      t.accel_valid = $urandom_range(0, 4) != 0;
      t.accel_x = rand_axis(calm);
      t.accel_y = rand_axis(calm);
      t.accel_z = rand_axis(calm);
      t.sos_press = calm ? ($urandom_range(0, 999) == 0) : ($urandom_range(0, 29) == 0);
      t.cancel_press = calm ? 1'b0 : ($urandom_range(0, 14) == 0);
      return t;
   endfunction

   function automatic logic [31:0] pick_timer(input int hi);
      case ($urandom_range(0, 9))
         0: return 32'd1;
         1: return 32'd65535;
         2: return $urandom_range(1, 65535);
         default: return $urandom_range(1, hi);
      endcase
   endfunction

   function automatic logic [31:0] pick_threshold();
      case ($urandom_range(0, 5))
         0: return RST_THRESHOLD_SQ;
         1: return 32'd16777216;
         2: return 32'd67108864;
         3: return 32'(longint'($urandom) % (longint'(THRESHOLD_MAX) + 1));
         4: return THRESHOLD_MAX;
         default: return $urandom_range(10000000, 150000000);
      endcase
   endfunction

   task automatic csr_write(input csr_index_type idx, input logic [31:0] val);
      logic [31:0] want;
      want = (idx == REG_THRESHOLD_SQ) ? val : {16'd0, val[15:0]};
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      // read back through a second transfer
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) begin
         $error("csr %s: expected %0h, got %0h", idx.name(), want, csr_prdata);
         errors++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_THRESHOLD_SQ: cfg_shadow.threshold_sq = val;
         REG_CANCEL_WINDOW: cfg_shadow.cancel_window = val[15:0];
         REG_IMPACT_HOLD: cfg_shadow.impact_hold = val[15:0];
         REG_BEEP: cfg_shadow.beep = val[15:0];
         REG_TOGGLE: cfg_shadow.toggle = val[15:0];
         default: cfg_shadow.report_period = val[15:0];
      endcase
      settings++;
   endtask

   task automatic send_tick(input tick_item_type t);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300)
                                                   : $urandom_range(1, 24);
      end
      req_ch.valid <= 1'b1;
      req_ch.accel_valid <= t.accel_valid;
      req_ch.accel_x <= t.accel_x;
      req_ch.accel_y <= t.accel_y;
      req_ch.accel_z <= t.accel_z;
      req_ch.sos_press <= t.sos_press;
      req_ch.cancel_press <= t.cancel_press;
      do @(posedge clock); while (!req_ch.ready);
      burst_left--;
      ticks_sent++;
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (results_seen < ticks_sent) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_random_cfg();
      csr_write(REG_THRESHOLD_SQ, pick_threshold());
      csr_write(REG_CANCEL_WINDOW, pick_timer(30));
      csr_write(REG_IMPACT_HOLD, pick_timer(80));
      csr_write(REG_BEEP, pick_timer(10));
      csr_write(REG_TOGGLE, pick_timer(8));
      csr_write(REG_REPORT_PERIOD, pick_timer(120));
   endtask

   task automatic check_field(input string name, input logic want, input logic got);
      if (got !== want) begin
         $error("%s: expected %0b, got %0b", name, want, got);
         errors++;
      end
   endtask

   // expected results of accepted ticks, typed rows override the predictor
   always @(posedge clock) begin : tick_monitor
      tick_item_type t;
      rsp_item_type pred;
      typed_hint_type h;
      if (!reset && req_ch.valid && req_ch.ready) begin
         t.accel_valid = req_ch.accel_valid;
         t.accel_x = req_ch.accel_x;
         t.accel_y = req_ch.accel_y;
         t.accel_z = req_ch.accel_z;
         t.sos_press = req_ch.sos_press;
         t.cancel_press = req_ch.cancel_press;
         pred = next_alert(t);
         if (hint_q.size() != 0) begin
            h = hint_q.pop_front();
            if (h.typed) pred = h.rsp;
         end
         alert_q.push_back(pred);
      end
   end

   always @(posedge clock) begin : result_monitor
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.buzzer_on = rsp_ch.buzzer_on;
         got.impact_flag = rsp_ch.impact_flag;
         got.report_valid = rsp_ch.report_valid;
         got.report_periodic = rsp_ch.report_periodic;
         got.report_impact = rsp_ch.report_impact;
         got.report_sos = rsp_ch.report_sos;
         results_seen++;
         n_impact += got.report_impact;
         n_sos += got.report_sos;
         n_periodic += got.report_periodic;
         if (alert_q.size() == 0) begin
            $error("result item with no tick waiting for it");
            errors++;
         end else begin
            want = alert_q.pop_front();
            check_field("buzzer_on", want.buzzer_on, got.buzzer_on);
            check_field("impact_flag", want.impact_flag, got.impact_flag);
            check_field("report_valid", want.report_valid, got.report_valid);
            check_field("report_periodic", want.report_periodic, got.report_periodic);
            check_field("report_impact", want.report_impact, got.report_impact);
            check_field("report_sos", want.report_sos, got.report_sos);
         end
      end
   end

   // result side stalls in modes that change at random
   initial begin : result_stall
      stall_mode_type mode;
      int phase;
      mode = STALL_NONE;
      phase = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (phase % 200 == 0) mode = stall_mode_type'($urandom_range(0, 3));
         case (mode)
            STALL_NONE: rsp_ch.ready <= 1'b1;
            STALL_RANDOM: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            STALL_COMB: rsp_ch.ready <= (phase % 13) >= 5;
            default: rsp_ch.ready <= (phase % 40) >= 20;
         endcase
         phase++;
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: no item moved for %0d cycles", STALL_LIMIT);
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin : stimulus
      typed_hint_type h;
      bit idle_now;
      reset <= 1'b1;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.accel_valid <= 1'b0;
      req_ch.accel_x <= '0;
      req_ch.accel_y <= '0;
      req_ch.accel_z <= '0;
      req_ch.sos_press <= 1'b0;
      req_ch.cancel_press <= 1'b0;
      cfg_shadow.threshold_sq = RST_THRESHOLD_SQ;
      cfg_shadow.cancel_window = RST_CANCEL_WINDOW;
      cfg_shadow.impact_hold = RST_IMPACT_HOLD;
      cfg_shadow.beep = RST_BEEP;
      cfg_shadow.toggle = RST_TOGGLE;
      cfg_shadow.report_period = RST_REPORT_PERIOD;

      // reset defaults first, result bits: buzzer impact valid periodic impact sos
      plan.push_back(known_row(tk(0, 0, 0, 0, 0, 0), 6'b000000));
      // cancel in the impact tick cannot abort it
      plan.push_back(known_row(tk(1, -32768, -32768, -32768, 0, 1), 6'b010000));
      plan.push_back(known_row(tk(0, 0, 0, 0, 0, 1), 6'b010000));
      plan.push_back(known_row(tk(0, 0, 0, 0, 1, 0), 6'b111001));
      plan.push_back(tick_row(tk(1, 32767, 32767, 32767, 0, 0)));
      plan.push_back(tick_row(tk(1, 32767, -1, 0, 0, 0)));
      // short timers, longest report period, zero threshold
      plan.push_back(cfg_row(REG_THRESHOLD_SQ, 32'd0));
      plan.push_back(cfg_row(REG_CANCEL_WINDOW, 32'd2));
      plan.push_back(cfg_row(REG_IMPACT_HOLD, 32'd6));
      plan.push_back(cfg_row(REG_BEEP, 32'd3));
      plan.push_back(cfg_row(REG_TOGGLE, 32'd1));
      plan.push_back(cfg_row(REG_REPORT_PERIOD, 32'd65535));
      plan.push_back(tick_row(tk(1, 0, 0, 0, 0, 0)));
      plan.push_back(tick_row(tk(1, 1, 0, 0, 0, 0)));
      plan.push_back(tick_row(tk(0, 0, 0, 0, 0, 0)));
      plan.push_back(tick_row(tk(0, 0, 0, 0, 0, 0)));
      plan.push_back(tick_row(tk(0, 0, 0, 0, 0, 1)));
      repeat (4) plan.push_back(tick_row(tk(0, 0, 0, 0, 0, 0)));
      // sos and impact together, then cancel while the beep runs
      plan.push_back(tick_row(tk(1, -32768, 0, 0, 1, 0)));
      plan.push_back(tick_row(tk(0, 0, 0, 0, 0, 1)));
      repeat (6) plan.push_back(tick_row(tk(0, 0, 0, 0, 0, 0)));
      // zero timers and a threshold equal to the largest magnitude
      plan.push_back(cfg_row(REG_THRESHOLD_SQ, THRESHOLD_MAX));
      plan.push_back(cfg_row(REG_CANCEL_WINDOW, 32'd0));
      plan.push_back(cfg_row(REG_BEEP, 32'd0));
      plan.push_back(cfg_row(REG_REPORT_PERIOD, 32'd0));
      plan.push_back(tick_row(tk(1, -32768, -32768, -32768, 0, 0)));
      plan.push_back(tick_row(tk(0, 0, 0, 0, 1, 0)));
      plan.push_back(cfg_row(REG_THRESHOLD_SQ, RST_THRESHOLD_SQ));
      plan.push_back(tick_row(tk(1, 10241, 0, 0, 0, 0)));
      plan.push_back(tick_row(tk(0, 0, 0, 0, 0, 0)));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_now = 1;
      foreach (plan[i]) begin
         if (plan[i].is_cfg) begin
            if (!idle_now) wait_idle();
            idle_now = 1;
            csr_write(plan[i].reg_idx, plan[i].reg_val);
         end else begin
            h.typed = plan[i].typed;
            h.rsp = plan[i].typed_rsp;
            hint_q.push_back(h);
            send_tick(plan[i].tick);
            idle_now = 0;
         end
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         write_random_cfg();
         repeat (PHASE_TICKS) send_tick(rand_tick(1'b0));
      end

      // wide timers and a short beep, with an impact held over quiet motion
      wait_idle();
      csr_write(REG_THRESHOLD_SQ, RST_THRESHOLD_SQ);
      csr_write(REG_CANCEL_WINDOW, 32'd65535);
      csr_write(REG_IMPACT_HOLD, 32'd65535);
      csr_write(REG_BEEP, 32'd5);
      csr_write(REG_TOGGLE, 32'd65535);
      csr_write(REG_REPORT_PERIOD, 32'd65535);
      send_tick(tk(1, -32768, 0, 0, 0, 0));
      repeat (CALM_TICKS) send_tick(rand_tick(1'b1));
      repeat (40) send_tick(rand_tick(1'b0));

      wait_idle();
      repeat (8) @(posedge clock);
      if (alert_q.size() != 0) begin
         $error("%0d expected result items never arrived", alert_q.size());
         errors++;
      end
      $display("tb: %0d ticks, %0d results over %0d register writes", ticks_sent,
               results_seen, settings);
      $display("tb: reports seen: %0d impact, %0d sos, %0d periodic", n_impact, n_sos,
               n_periodic);
      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
